// ----- rtl/core/sdoe_pkg.sv -----
// ----------------------------------------------------------------------------
// sdoe_pkg
// shared types and constants of the stack/deque opcode engine
// ----------------------------------------------------------------------------
package sdoe_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int MAX_RESULTS = 32;
   localparam int CHAR_MAX = 127;
   localparam int FIFO_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_MOD   = 3'd1,
      OP_PCHAR = 3'd2,
      OP_PSTR  = 3'd3,
      OP_ROTL  = 3'd4,
      OP_ROTR  = 3'd5,
      OP_NOP6  = 3'd6,
      OP_NOP7  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_SHORT   = 3'd1,
      ST_DIVZERO = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_RANGE   = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] value;
   } cmd_type;

   // true when a stored word is a printable code 1..127
   function automatic logic is_char(input logic [31:0] v);
      is_char = !v[31] && (v[30:7] == '0) && (v[6:0] != 7'd0);
   endfunction

endpackage

// ----- rtl/core/sdoe_ram.sv -----
// ----------------------------------------------------------------------------
// sdoe_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module sdoe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- rtl/core/sdoe_front.sv -----
// ----------------------------------------------------------------------------
// sdoe_front
// command intake and two-entry queue toward the execution unit
// ----------------------------------------------------------------------------
module sdoe_front
   import sdoe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_push_value,
   output logic        busy,
   output logic        q_valid,
   output cmd_type     q_cmd,
   input  logic        q_take,
   output logic        q_empty
);
   cmd_type     slot_ff [FIFO_DEPTH];
   logic        wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   cmd_type     in_cmd;

   // a shallow queue: busy is raised once both entries are full
   assign busy    = (cnt_ff == 2'(FIFO_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_empty = !q_valid;
   assign q_cmd   = slot_ff[rp_ff];
   assign in_cmd  = '{op: op_type'(req_op), value: req_push_value};

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = (q_take && q_valid) ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= in_cmd;
      end
   end
endmodule

// ----- rtl/core/sdoe_divider.sv -----
// ----------------------------------------------------------------------------
// sdoe_divider
// restoring signed remainder, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sdoe_divider
   import sdoe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] remainder
);
   logic [31:0] num_ff, den_ff, rem_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff, run_ff, done_ff;
   logic [32:0] trial;
   logic [31:0] shifted;

   assign shifted   = {rem_ff[30:0], num_ff[31]};
   assign trial     = {1'b0, shifted} - {1'b0, den_ff};
   assign done      = done_ff;
   assign remainder = neg_ff ? (32'd0 - rem_ff) : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd32;
            num_ff <= dividend[31] ? (32'd0 - dividend) : dividend;
            den_ff <= divisor[31] ? (32'd0 - divisor) : divisor;
            neg_ff <= dividend[31];
            rem_ff <= '0;
         end else if (run_ff) begin
            num_ff <= {num_ff[30:0], 1'b0};
            rem_ff <= trial[32] ? shifted : trial[31:0];
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// ----- rtl/core/sdoe_back.sv -----
// ----------------------------------------------------------------------------
// sdoe_back
// execution unit: walks the circular store and emits results
// ----------------------------------------------------------------------------
module sdoe_back
   import sdoe_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_mode,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_take,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_char_code,
   output logic        rsp_char_valid,
   output logic        rsp_last
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [AW-1:0] LAST_POS = AW'(STACK_DEPTH - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_WAIT, S_EXEC, S_RD2, S_WAIT2, S_DIV, S_PSTR, S_WRITE
   } state_type;

   state_type      state_ff;
   cmd_type        cmd_ff;
   logic [AW-1:0]  top_ff, pos_ff;
   logic [CW-1:0]  count_ff, left_ff;
   logic [5:0]     n_ff;
   logic [31:0]    b_ff;
   logic [6:0]     char_ff;
   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [31:0]    wr_data, rd_data;
   logic           div_go, div_done;
   logic [31:0]    div_rem;
   logic [AW-1:0]  bottom;

   function automatic logic [AW-1:0] dec(input logic [AW-1:0] p);
      dec = (p == '0) ? LAST_POS : p - AW'(1);
   endfunction
   function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
      inc = (p == LAST_POS) ? '0 : p + AW'(1);
   endfunction

   // bottom = top - (count-1) modulo depth
   always_comb begin
      logic [AW:0] diff;
      diff = {1'b0, top_ff} - (AW+1)'(count_ff - CW'(1));
      if (diff[AW] || diff >= (AW+1)'(STACK_DEPTH))
         bottom = AW'(diff + (AW+1)'(STACK_DEPTH));
      else
         bottom = AW'(diff);
   end

   sdoe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   sdoe_divider u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(rd_data),
      .divisor(b_ff), .done(div_done), .remainder(div_rem)
   );

   assign q_take = (state_ff == S_IDLE) && q_valid;
   assign div_go = (state_ff == S_WAIT2);

   always_comb begin
      rd_addr = top_ff;
      if (state_ff == S_RD2) rd_addr = dec(top_ff);
      if (state_ff == S_WAIT && cmd_ff.op == OP_ROTR) rd_addr = bottom;
      if (state_ff == S_PSTR) rd_addr = dec(pos_ff);
      if (state_ff == S_RD) rd_addr = pos_ff;
   end

   // store write port, driven by the exec and write states
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = inc(top_ff);
      wr_data = cmd_ff.value;
      if (state_ff == S_EXEC) begin
         if (cmd_ff.op == OP_PUSH && count_ff != CW'(STACK_DEPTH)) begin
            wr_en   = 1'b1;
            wr_addr = (count_ff == '0 || !queue_mode) ? inc(top_ff) : dec(bottom);
         end else if (cmd_ff.op == OP_ROTL && count_ff >= CW'(2)) begin
            wr_en   = 1'b1;
            wr_addr = dec(bottom);
            wr_data = rd_data;
         end else if (cmd_ff.op == OP_ROTR && count_ff >= CW'(2)) begin
            wr_en   = 1'b1;
            wr_addr = inc(top_ff);
            wr_data = rd_data;
         end
      end else if (state_ff == S_WRITE) begin
         wr_en   = 1'b1;
         wr_addr = (count_ff == '0 || !queue_mode) ? inc(top_ff) : dec(bottom);
         wr_data = b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         top_ff    <= '0;
         count_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff   <= q_cmd;
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: state_ff <= S_EXEC;
            S_EXEC: begin
               rsp_valid      <= 1'b1;
               rsp_status     <= ST_OK;
               rsp_char_code  <= '0;
               rsp_char_valid <= 1'b0;
               rsp_last       <= 1'b1;
               state_ff       <= S_IDLE;
               case (cmd_ff.op)
                  OP_PUSH: begin
                     if (count_ff == CW'(STACK_DEPTH)) rsp_status <= ST_FULL;
                     else begin
                        if (count_ff == '0 || !queue_mode) top_ff <= inc(top_ff);
                        count_ff <= count_ff + CW'(1);
                     end
                  end
                  OP_MOD: begin
                     if (count_ff < CW'(2)) rsp_status <= ST_SHORT;
                     else if (rd_data == '0) begin
                        rsp_status <= ST_DIVZERO;
                        top_ff     <= dec(top_ff);
                        count_ff   <= count_ff - CW'(1);
                     end else begin
                        rsp_valid <= 1'b0;
                        b_ff      <= rd_data;
                        state_ff  <= S_RD2;
                     end
                  end
                  OP_PCHAR: begin
                     if (count_ff == '0) rsp_status <= ST_EMPTY;
                     else if (!is_char(rd_data)) rsp_status <= ST_RANGE;
                     else begin
                        rsp_char_code  <= rd_data[6:0];
                        rsp_char_valid <= 1'b1;
                     end
                  end
                  OP_PSTR: begin
                     if (count_ff == '0 || !is_char(rd_data)) begin
                        rsp_status <= ST_OK;
                     end else begin
                        rsp_valid <= 1'b0;
                        pos_ff    <= top_ff;
                        left_ff   <= count_ff;
                        n_ff      <= '0;
                        state_ff  <= S_PSTR;
                     end
                  end
                  OP_ROTL: if (count_ff >= CW'(2)) top_ff <= dec(top_ff);
                  OP_ROTR: if (count_ff >= CW'(2)) top_ff <= inc(top_ff);
                  default: ;
               endcase
            end
            S_RD2: state_ff <= S_WAIT2;
            S_WAIT2: begin
               // pop both operands; rd_data holds next value
               top_ff   <= dec(dec(top_ff));
               count_ff <= count_ff - CW'(2);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  b_ff     <= (b_ff == 32'hFFFF_FFFF) ? 32'd0 : div_rem;
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (count_ff == '0 || !queue_mode) top_ff <= inc(top_ff);
               count_ff       <= count_ff + CW'(1);
               rsp_valid      <= 1'b1;
               rsp_status     <= ST_OK;
               rsp_char_code  <= '0;
               rsp_char_valid <= 1'b0;
               rsp_last       <= 1'b1;
               state_ff       <= S_IDLE;
            end
            S_PSTR: begin
               // rd_data holds word at pos_ff, already known printable
               if (left_ff == CW'(1) || n_ff == 6'(MAX_RESULTS - 1)) begin
                  rsp_valid      <= 1'b1;
                  rsp_status     <= ST_OK;
                  rsp_char_code  <= rd_data[6:0];
                  rsp_char_valid <= 1'b1;
                  rsp_last       <= 1'b1;
                  state_ff       <= S_IDLE;
               end else begin
                  // hold the character until the next word tells if it ends
                  char_ff  <= rd_data[6:0];
                  pos_ff   <= dec(pos_ff);
                  left_ff  <= left_ff - CW'(1);
                  n_ff     <= n_ff + 6'd1;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               // next word is in; emit the held character, last if the walk stops
               rsp_valid      <= 1'b1;
               rsp_status     <= ST_OK;
               rsp_char_code  <= char_ff;
               rsp_char_valid <= 1'b1;
               rsp_last       <= !is_char(rd_data);
               state_ff       <= is_char(rd_data) ? S_PSTR : S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/core/stack_deque_opcode_engine_top.sv -----
// ----------------------------------------------------------------------------
// stack_deque_opcode_engine_top
// bounded stack/deque opcode engine with command intake and execution unit
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   req_op, req_push_value             start && !busy
//  response  rsp_status, rsp_char_code,         rsp_valid, one cycle,
//            rsp_char_valid, rsp_last           no stall
//  config    csr_queue_mode                     csr_wr_en
//
// most opcodes pass the execution unit through a take, a store read and an
// execute state, and the response is registered in the execute state;
// mod adds a second store read and waits on the one-bit-per-cycle divider,
// pstr walks the entries through one store read port, a read and an emit state per character;
// a two-entry queue in front holds items while the back works. busy is high
// only while that queue is full. reset is synchronous and empties store, queue and mode.
module stack_deque_opcode_engine_top
   import sdoe_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_push_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_char_code,
   output logic        rsp_char_valid,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_queue_mode
);
   logic    queue_mode_ff;
   logic    q_valid, q_take, q_empty;
   cmd_type q_cmd;

   // mode register, to be written only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) queue_mode_ff <= 1'b0;
      else if (csr_wr_en) queue_mode_ff <= csr_queue_mode;
   end

   sdoe_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_op(req_op),
      .req_push_value(req_push_value), .busy(busy), .q_valid(q_valid),
      .q_cmd(q_cmd), .q_take(q_take), .q_empty(q_empty)
   );

   sdoe_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock(clock), .reset(reset), .queue_mode(queue_mode_ff),
      .q_valid(q_valid && !q_empty), .q_cmd(q_cmd), .q_take(q_take),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_char_code(rsp_char_code), .rsp_char_valid(rsp_char_valid),
      .rsp_last(rsp_last)
   );
endmodule
